// ===== hdl/kst_pkg.sv =====
package kst_pkg;

    localparam int VERTEX_CAPACITY = 64;
    localparam int EDGE_CAPACITY   = 64;
    localparam int WEIGHT_BITS     = 16;

    localparam int VW  = 6;
    localparam int VCW = 7;
    localparam int EAW = $clog2(EDGE_CAPACITY);
    localparam int ECW = $clog2(EDGE_CAPACITY + 1);
    localparam int PAW = $clog2(VERTEX_CAPACITY);
    localparam int TCW = $clog2(VERTEX_CAPACITY);
    localparam int EDW = 2 * VW + WEIGHT_BITS;

    localparam logic [VCW-1:0] VC_RESET = VCW'(VERTEX_CAPACITY);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_PASS_START,
        OP_SCAN,
        OP_FIND_SRC,
        OP_FIND_DST,
        OP_FIND_STEP,
        OP_JOIN,
        OP_FINAL
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic scan_done;
        logic found;
        logic hit;
        logic same_root;
        logic tree_full;
        logic out_free;
        logic trivial;
        logic pend_valid;
    } sts_t;

endpackage

// ===== hdl/kst_ram.sv =====
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/kst_datapath.sv =====
module kst_datapath
    import kst_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output sts_t                          sts,
    input  logic                          in_fire,
    input  logic [VW-1:0]                 edge_src,
    input  logic [VW-1:0]                 edge_dest,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic                          cfg_fire,
    input  logic [VCW-1:0]                cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [VW-1:0]                 tree_src,
    output logic [VW-1:0]                 tree_dest,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          last_of_tree,
    output logic                          no_edge,
    output logic                          edges_dropped
);

    logic [VCW-1:0] vc_reg;
    logic [VCW-1:0] nv;
    logic [ECW-1:0] fill_reg;
    logic           ovf_reg;
    logic [ECW-1:0] idx_reg;
    logic           rd_pend_reg;
    logic [EAW-1:0] rd_idx_reg;
    logic           have_prev_reg;
    logic           found_reg;
    logic           pend_valid_reg;
    logic [TCW-1:0] taken_reg;
    logic           out_valid_reg;

    logic signed [WEIGHT_BITS-1:0] prev_w_reg, best_w_reg, pend_w_reg;
    logic [EAW-1:0]                prev_i_reg, best_i_reg;
    logic [VW-1:0]                 best_src_reg, best_dest_reg;
    logic [VW-1:0]                 pend_src_reg, pend_dest_reg;
    logic [VW-1:0]                 node_reg, root_src_reg;

    logic [EDW-1:0]                e_rd;
    logic [VW-1:0]                 e_src, e_dest;
    logic signed [WEIGHT_BITS-1:0] e_w;
    logic                          ep_ok, e_wr, gt_prev, lt_best, take;

    logic           p_wr;
    logic [PAW-1:0] p_wr_addr, p_rd_addr;
    logic [VW-1:0]  p_wr_data, p_rd;
    logic           out_free;
    logic           out_load;

    assign nv = (vc_reg == '0) ? VCW'(1)
              : (vc_reg > VC_RESET) ? VC_RESET : vc_reg;

    assign ep_ok = (VCW'(edge_src) < nv) && (VCW'(edge_dest) < nv);
    assign e_wr  = in_fire && ep_ok && (fill_reg < ECW'(EDGE_CAPACITY));

    kst_ram #(.WIDTH(EDW), .DEPTH(EDGE_CAPACITY)) u_edge_ram (
        .clk     (clk),
        .wr_en   (e_wr),
        .wr_addr (fill_reg[EAW-1:0]),
        .wr_data ({edge_src, edge_dest, edge_weight}),
        .rd_addr (idx_reg[EAW-1:0]),
        .rd_data (e_rd)
    );

    assign e_src  = e_rd[EDW-1 -: VW];
    assign e_dest = e_rd[WEIGHT_BITS +: VW];
    assign e_w    = $signed(e_rd[WEIGHT_BITS-1:0]);

    assign gt_prev = !have_prev_reg || (e_w > prev_w_reg)
                   || ((e_w == prev_w_reg) && (rd_idx_reg > prev_i_reg));
    assign lt_best = !found_reg || (e_w < best_w_reg);
    assign take    = rd_pend_reg && gt_prev && lt_best;

    always_comb
    begin
        p_wr      = 1'b0;
        p_wr_addr = idx_reg[PAW-1:0];
        p_wr_data = VW'(idx_reg);
        p_rd_addr = node_reg;
        case (cmd.op)
            OP_INIT:
            begin
                p_wr = 1'b1;
            end
            OP_JOIN:
            begin
                p_wr      = 1'b1;
                p_wr_addr = root_src_reg;
                p_wr_data = node_reg;
            end
            OP_FIND_SRC:  p_rd_addr = best_src_reg;
            OP_FIND_DST:  p_rd_addr = best_dest_reg;
            OP_FIND_STEP: p_rd_addr = p_rd;
            default:      p_rd_addr = node_reg;
        endcase
    end

    kst_ram #(.WIDTH(VW), .DEPTH(VERTEX_CAPACITY)) u_parent_ram (
        .clk     (clk),
        .wr_en   (p_wr),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = ((cmd.op == OP_JOIN) && pend_valid_reg) || (cmd.op == OP_FINAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg         <= VC_RESET;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            have_prev_reg  <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            taken_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                vc_reg <= cfg_data;
            end
            if (in_fire)
            begin
                idx_reg       <= '0;
                have_prev_reg <= 1'b0;
                if (e_wr)
                begin
                    fill_reg <= fill_reg + ECW'(1);
                end
                else if (ep_ok)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= (cmd.op == OP_SCAN) && (idx_reg < fill_reg);
            if (take)
            begin
                found_reg <= 1'b1;
            end
            case (cmd.op)
                OP_INIT:
                begin
                    idx_reg <= idx_reg + ECW'(1);
                end
                OP_PASS_START:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    if (idx_reg < fill_reg)
                    begin
                        idx_reg <= idx_reg + ECW'(1);
                    end
                end
                OP_FIND_SRC:
                begin
                    have_prev_reg <= 1'b1;
                end
                OP_JOIN:
                begin
                    taken_reg      <= taken_reg + TCW'(1);
                    pend_valid_reg <= 1'b1;
                end
                OP_FINAL:
                begin
                    pend_valid_reg <= 1'b0;
                    taken_reg      <= '0;
                    fill_reg       <= '0;
                    ovf_reg        <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg[EAW-1:0];
        if (take)
        begin
            best_w_reg    <= e_w;
            best_i_reg    <= rd_idx_reg;
            best_src_reg  <= e_src;
            best_dest_reg <= e_dest;
        end
        case (cmd.op)
            OP_FIND_SRC:
            begin
                prev_w_reg <= best_w_reg;
                prev_i_reg <= best_i_reg;
                node_reg   <= best_src_reg;
            end
            OP_FIND_DST:
            begin
                root_src_reg <= node_reg;
                node_reg     <= best_dest_reg;
            end
            OP_FIND_STEP:
            begin
                node_reg <= p_rd;
            end
            OP_JOIN:
            begin
                pend_src_reg  <= best_src_reg;
                pend_dest_reg <= best_dest_reg;
                pend_w_reg    <= best_w_reg;
                if (pend_valid_reg)
                begin
                    tree_src      <= pend_src_reg;
                    tree_dest     <= pend_dest_reg;
                    tree_weight   <= pend_w_reg;
                    last_of_tree  <= 1'b0;
                    no_edge       <= 1'b0;
                    edges_dropped <= ovf_reg;
                end
            end
            OP_FINAL:
            begin
                tree_src      <= pend_valid_reg ? pend_src_reg : '0;
                tree_dest     <= pend_valid_reg ? pend_dest_reg : '0;
                tree_weight   <= pend_valid_reg ? pend_w_reg : '0;
                last_of_tree  <= 1'b1;
                no_edge       <= !pend_valid_reg;
                edges_dropped <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    assign sts.init_last  = (idx_reg[PAW-1:0] == PAW'(VERTEX_CAPACITY - 1));
    assign sts.scan_done  = (idx_reg >= fill_reg) && !rd_pend_reg;
    assign sts.found      = found_reg;
    assign sts.hit        = (p_rd == node_reg);
    assign sts.same_root  = (node_reg == root_src_reg);
    assign sts.tree_full  = (VCW'(taken_reg) + VCW'(1)) == (nv - VCW'(1));
    assign sts.out_free   = out_free;
    assign sts.trivial    = (nv <= VCW'(1));
    assign sts.pend_valid = pend_valid_reg;

endmodule

// ===== hdl/kst_ctrl.sv =====
module kst_ctrl
    import kst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_edge,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_PASS,
        ST_SCAN,
        ST_FSRC,
        ST_FSW,
        ST_FDST,
        ST_FDW,
        ST_JOIN,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;
    logic   in_fire;

    assign in_fire  = in_valid && in_ready_reg;
    assign in_ready = in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && last_edge)
                begin
                    state_next = sts.trivial ? ST_FINAL : ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.op = OP_INIT;
                if (sts.init_last)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                cmd.op     = OP_PASS_START;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (sts.scan_done)
                begin
                    state_next = sts.found ? ST_FSRC : ST_FINAL;
                end
            end
            ST_FSRC:
            begin
                cmd.op     = OP_FIND_SRC;
                state_next = ST_FSW;
            end
            ST_FSW:
            begin
                cmd.op = OP_FIND_STEP;
                if (sts.hit)
                begin
                    state_next = ST_FDST;
                end
            end
            ST_FDST:
            begin
                cmd.op     = OP_FIND_DST;
                state_next = ST_FDW;
            end
            ST_FDW:
            begin
                cmd.op = OP_FIND_STEP;
                if (sts.hit)
                begin
                    state_next = sts.same_root ? ST_PASS : ST_JOIN;
                end
            end
            ST_JOIN:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.op     = OP_JOIN;
                    state_next = sts.tree_full ? ST_FINAL : ST_PASS;
                end
            end
            ST_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_FINAL;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_LOAD);
        end
    end

endmodule

// ===== hdl/kruskal_spanning_tree_core.sv =====
// Minimum spanning tree engine (Kruskal, union-find).
// Input channel (in_valid/in_ready): one edge word per cycle while loading:
// edge_src, edge_dest, signed edge_weight. The word with last_edge set is
// stored and starts the run; in_ready stays low until the run has finished.
// Edges with an endpoint at or above vertex_count are ignored; edges beyond
// the 64-entry store are dropped and flagged on every result of that run.
// Config channel (cfg_valid/cfg_ready, cfg_data): vertex_count, written idle.
// Output channel (out_valid/out_ready): tree edges in acceptance order,
// last_of_tree on the final one; a run with no tree edge gives one word with
// no_edge set.
// Run after the last edge: parent init of all 64 vertices, then for each edge
// in weight order one scan of the edge store, a parent walk from each
// endpoint to its root and, unless both endpoints share a root, a join;
// then one final step. Run time is bound by the single edge store read port.
// Reset empties the store and sets vertex_count to 64. A stalled receiver
// holds the run at its next result; one result waits in the output register.
module kruskal_spanning_tree_core
    import kst_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [VW-1:0]                 edge_src,
    input  logic [VW-1:0]                 edge_dest,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic                          last_edge,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [VCW-1:0]                cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [VW-1:0]                 tree_src,
    output logic [VW-1:0]                 tree_dest,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          last_of_tree,
    output logic                          no_edge,
    output logic                          edges_dropped
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    kst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (last_edge),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kst_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_fire       (in_valid && in_ready),
        .edge_src      (edge_src),
        .edge_dest     (edge_dest),
        .edge_weight   (edge_weight),
        .cfg_fire      (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .tree_src      (tree_src),
        .tree_dest     (tree_dest),
        .tree_weight   (tree_weight),
        .last_of_tree  (last_of_tree),
        .no_edge       (no_edge),
        .edges_dropped (edges_dropped)
    );

endmodule

// ===== hdl/kst_checker.sv =====
module kst_checker
    import kst_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          last_edge,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [VW-1:0]                 tree_src,
    input logic [VW-1:0]                 tree_dest,
    input logic signed [WEIGHT_BITS-1:0] tree_weight,
    input logic                          last_of_tree,
    input logic                          no_edge
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn before it was taken");

    a_no_edge_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_edge |-> last_of_tree)
        else $error("no_edge word not marked last");

    a_no_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_edge |-> tree_src == '0 && tree_dest == '0 && tree_weight == '0)
        else $error("no_edge word carries nonzero fields");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_edge |=> in_ready)
        else $error("loading stalled after a non-final edge");

endmodule

bind kruskal_spanning_tree_core kst_checker u_kst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_edge    (last_edge),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tree_src     (tree_src),
    .tree_dest    (tree_dest),
    .tree_weight  (tree_weight),
    .last_of_tree (last_of_tree),
    .no_edge      (no_edge)
);
